[rtl/core/oas_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the overlap alignment scorer.
// No dependencies; imported by oas_front, oas_jobq, oas_back and the top level.
package oas_pkg;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] CfgMismatch  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgIndel     = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgUnaligned = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgLimit     = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgMinOvl    = 3'd4;

  localparam logic OpFirst  = 1'b0;
  localparam logic OpSecond = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] symbol;
    logic       last;
  } item_t;

  typedef struct packed {
    logic        no_match;
    logic [15:0] score;
    logic [7:0]  start_first;
    logic [7:0]  end_second;
    logic [7:0]  aligned_pairs;
    logic [7:0]  identical_pairs;
  } result_t;

  typedef struct packed {
    logic [7:0]  mismatch_cost;
    logic [7:0]  indel_cost;
    logic [7:0]  unaligned_cost;
    logic [15:0] penalty_limit;
    logic [7:0]  min_overlap;
  } cfg_t;

endpackage

[rtl/core/oas_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oas_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

[rtl/core/oas_front.sv]
`timescale 1ns / 1ps
// Front end: takes symbol transactions, fills both symbol stores, issues jobs.
// Depends on oas_pkg.
module oas_front #(
  parameter int MaxLen     = 128,
  parameter int SymbolBits = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  oas_pkg::item_t              item_i,
  output logic                        fst_we_o,
  output logic                        snd_we_o,
  output logic [$clog2(MaxLen)-1:0]   waddr_o,
  output logic [SymbolBits-1:0]       wdata_o,
  output logic                        push_o,
  output logic [$clog2(MaxLen+1)-1:0] n1_o,
  output logic [$clog2(MaxLen+1)-1:0] n2_o
);
  import oas_pkg::*;
  localparam int LW = $clog2(MaxLen + 1);
  localparam int AW = $clog2(MaxLen);

  logic [LW-1:0] n1_q, n1_d, n2_q, n2_d, n1_base;
  logic          closed_q, closed_d;
  logic          is_fst, room;

  always_comb begin
    is_fst   = (item_i.opcode == OpFirst);
    n1_base  = closed_q ? '0 : n1_q;
    room     = is_fst ? (n1_base < LW'(MaxLen)) : (n2_q < LW'(MaxLen));
    fst_we_o = accept_i && is_fst && room;
    snd_we_o = accept_i && !is_fst && room;
    waddr_o  = is_fst ? n1_base[AW-1:0] : n2_q[AW-1:0];
    wdata_o  = item_i.symbol[SymbolBits-1:0];
    push_o   = accept_i && !is_fst && item_i.last;
    n1_o     = n1_q;
    n2_o     = room ? n2_q + LW'(1) : n2_q;
    n1_d     = n1_q;
    n2_d     = n2_q;
    closed_d = closed_q;
    if (accept_i) begin
      if (is_fst) begin
        n1_d     = room ? n1_base + LW'(1) : n1_base;
        closed_d = item_i.last;
      end else if (item_i.last) begin
        n1_d     = '0;
        n2_d     = '0;
        closed_d = 1'b0;
      end else begin
        n2_d = n2_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_q     <= '0;
      n2_q     <= '0;
      closed_q <= 1'b0;
    end else begin
      n1_q     <= n1_d;
      n2_q     <= n2_d;
      closed_q <= closed_d;
    end
  end
endmodule

[rtl/core/oas_jobq.sv]
`timescale 1ns / 1ps
// Two-entry job queue carrying sequence lengths from front to back.
// Depends on oas_pkg.
module oas_jobq #(
  parameter int LW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [LW-1:0] n1_i,
  input  logic [LW-1:0] n2_i,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [LW-1:0] n1_o,
  output logic [LW-1:0] n2_o
);
  import oas_pkg::*;
  logic [2*LW-1:0] ent_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign n1_o    = ent_q[rp_q][2*LW-1:LW];
  assign n2_o    = ent_q[rp_q][LW-1:0];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= {n1_i, n2_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

[rtl/core/oas_back.sv]
`timescale 1ns / 1ps
// Back end: fills the score table, picks the end column and traces back.
// Depends on oas_pkg; drives the symbol RAM read ports and both table RAM ports.
module oas_back #(
  parameter int MaxLen     = 128,
  parameter int ScoreBits  = 16,
  parameter int SymbolBits = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  oas_pkg::cfg_t                       cfg_i,
  input  logic                                job_empty_i,
  input  logic [$clog2(MaxLen+1)-1:0]         job_n1_i,
  input  logic [$clog2(MaxLen+1)-1:0]         job_n2_i,
  output logic                                job_pop_o,
  output logic                                busy_o,
  output logic                                fst_re_o,
  output logic [$clog2(MaxLen)-1:0]           fst_raddr_o,
  input  logic [SymbolBits-1:0]               fst_rdata_i,
  output logic                                snd_re_o,
  output logic [$clog2(MaxLen)-1:0]           snd_raddr_o,
  input  logic [SymbolBits-1:0]               snd_rdata_i,
  output logic                                tbl_we_o,
  output logic [$clog2((MaxLen+1)**2)-1:0]    tbl_waddr_o,
  output logic [ScoreBits-1:0]                tbl_wdata_o,
  output logic                                tbl_re_o,
  output logic [$clog2((MaxLen+1)**2)-1:0]    tbl_raddr_o,
  input  logic [ScoreBits-1:0]                tbl_rdata_i,
  output logic                                res_valid_o,
  output oas_pkg::result_t                    res_o
);
  import oas_pkg::*;
  localparam int LW   = $clog2(MaxLen + 1);
  localparam int SAW  = $clog2(MaxLen);
  localparam int TAW  = $clog2((MaxLen + 1) ** 2);
  localparam int SB   = ScoreBits;
  localparam int CW   = (ScoreBits > 16) ? ScoreBits : 16;
  localparam int XW   = LW + 9;
  localparam int RowW = MaxLen + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_ROW   = 4'd2;
  localparam logic [3:0] S_CRD   = 4'd3;
  localparam logic [3:0] S_CWR   = 4'd4;
  localparam logic [3:0] S_REND  = 4'd5;
  localparam logic [3:0] S_EINIT = 4'd6;
  localparam logic [3:0] S_ERD   = 4'd7;
  localparam logic [3:0] S_ECMP  = 4'd8;
  localparam logic [3:0] S_EDONE = 4'd9;
  localparam logic [3:0] S_TCHK  = 4'd10;
  localparam logic [3:0] S_TR1   = 4'd11;
  localparam logic [3:0] S_TR2   = 4'd12;
  localparam logic [3:0] S_TD    = 4'd13;

  function automatic logic [SB-1:0] sadd(input logic [SB-1:0] a, input logic [SB-1:0] b);
    logic [SB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SB] ? {SB{1'b1}} : s[SB-1:0];
  endfunction

  function automatic logic [TAW-1:0] tix(input logic [LW-1:0] i, input logic [LW-1:0] j);
    return TAW'(i) * TAW'(RowW) + TAW'(j);
  endfunction

  logic [3:0]    state_q, state_d;
  logic [LW-1:0] i_q, i_d, j_q, j_d, n1_q, n1_d, n2_q, n2_d, bj_q, bj_d;
  logic [SB-1:0] left_q, left_d, diag_q, diag_d, col0_q, col0_d, ua_q, ua_d;
  logic [SB-1:0] rmin_q, rmin_d, tr_q, tr_d, best_q, best_d, cur_q, cur_d, dg_q, dg_d;
  logic          found_q, found_d;
  logic [7:0]    al_q, al_d, id_q, id_d;
  logic          rv_q, rv_d;
  result_t       res_q, res_d;

  logic [SB-1:0] mis, ind, una, lim_s, ca, cb, cc, cm, ev, ua_nx;
  logic [CW-1:0] lim_w;
  logic          eq;
  logic [XW-1:0] i_x, j_x, n1_x, mo_x;

  always_comb begin
    mis   = SB'(cfg_i.mismatch_cost);
    ind   = SB'(cfg_i.indel_cost);
    una   = SB'(cfg_i.unaligned_cost);
    lim_w = CW'(cfg_i.penalty_limit);
    lim_s = (lim_w > CW'({SB{1'b1}})) ? {SB{1'b1}} : lim_w[SB-1:0];
    eq    = (fst_rdata_i == snd_rdata_i);
    ca    = sadd(diag_q, eq ? '0 : mis);
    cb    = sadd(left_q, ind);
    cc    = sadd(tbl_rdata_i, ind);
    cm    = (ca < cb) ? ca : cb;
    cm    = (cc < cm) ? cc : cm;
    ev    = sadd(tbl_rdata_i, tr_q);
    ua_nx = sadd(ua_q, una);
    i_x   = XW'(i_q);
    j_x   = XW'(j_q);
    n1_x  = XW'(n1_q);
    mo_x  = XW'(cfg_i.min_overlap);
  end

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; n1_d = n1_q; n2_d = n2_q; bj_d = bj_q;
    left_d = left_q; diag_d = diag_q; col0_d = col0_q; ua_d = ua_q;
    rmin_d = rmin_q; tr_d = tr_q; best_d = best_q; cur_d = cur_q; dg_d = dg_q;
    found_d = found_q; al_d = al_q; id_d = id_q;
    rv_d = 1'b0; res_d = res_q;
    job_pop_o   = 1'b0;
    fst_re_o    = 1'b0;
    fst_raddr_o = SAW'(i_q - LW'(1));
    snd_re_o    = 1'b0;
    snd_raddr_o = SAW'(j_q - LW'(1));
    tbl_we_o    = 1'b0;
    tbl_waddr_o = tix(i_q, j_q);
    tbl_wdata_o = cm;
    tbl_re_o    = 1'b0;
    tbl_raddr_o = tix(i_q, j_q);

    unique case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          n1_d = job_n1_i;
          n2_d = job_n2_i;
          i_d = '0; j_d = '0; left_d = '0; col0_d = '0; ua_d = '0;
          state_d = S_INIT;
        end
      end
      // row 0: running sum of indel costs
      S_INIT: begin
        tbl_we_o    = 1'b1;
        tbl_wdata_o = left_q;
        left_d      = sadd(left_q, ind);
        j_d         = j_q + LW'(1);
        if (j_q == n2_q) begin
          i_d = LW'(1);
          state_d = (n1_q == '0) ? S_EINIT : S_ROW;
        end
      end
      S_ROW: begin
        j_d = '0;
        ua_d = ua_nx;
        tbl_we_o    = 1'b1;
        tbl_waddr_o = tix(i_q, '0);
        tbl_wdata_o = ((i_x + mo_x) < n1_x) ? ua_nx : lim_s;
        left_d = tbl_wdata_o;
        diag_d = col0_q;
        col0_d = tbl_wdata_o;
        rmin_d = {SB{1'b1}};
        fst_re_o = 1'b1;
        j_d = LW'(1);
        state_d = (n2_q == '0) ? S_REND : S_CRD;
      end
      S_CRD: begin
        tbl_re_o    = 1'b1;
        tbl_raddr_o = tix(i_q - LW'(1), j_q);
        snd_re_o    = 1'b1;
        state_d     = S_CWR;
      end
      S_CWR: begin
        tbl_we_o = 1'b1;
        left_d   = cm;
        diag_d   = tbl_rdata_i;
        if (cm < rmin_q) rmin_d = cm;
        j_d      = j_q + LW'(1);
        state_d  = (j_q == n2_q) ? S_REND : S_CRD;
      end
      S_REND: begin
        if (CW'(rmin_q) >= lim_w) begin
          rv_d  = 1'b1;
          res_d = '0;
          res_d.no_match = 1'b1;
          res_d.score    = cfg_i.penalty_limit;
          state_d = S_IDLE;
        end else if (i_q == n1_q) begin
          state_d = S_EINIT;
        end else begin
          i_d = i_q + LW'(1);
          state_d = S_ROW;
        end
      end
      S_EINIT: begin
        i_d = n1_q;
        j_d = n2_q;
        tr_d = '0;
        best_d = {SB{1'b1}};
        found_d = 1'b0;
        bj_d = '0;
        state_d = (XW'(n2_q) <= mo_x) ? S_EDONE : S_ERD;
      end
      S_ERD: begin
        tbl_re_o = 1'b1;
        state_d  = S_ECMP;
      end
      // scan downwards; ties go to the smaller column
      S_ECMP: begin
        if (ev <= best_q && ev != {SB{1'b1}}) begin
          best_d = ev;
          bj_d = j_q;
          found_d = 1'b1;
        end
        tr_d = sadd(tr_q, una);
        j_d  = j_q - LW'(1);
        state_d = (j_x <= mo_x + XW'(1)) ? S_EDONE : S_ERD;
      end
      S_EDONE: begin
        if (!found_q) begin
          rv_d  = 1'b1;
          res_d = '0;
          res_d.no_match = 1'b1;
          res_d.score    = cfg_i.penalty_limit;
          state_d = S_IDLE;
        end else begin
          i_d = n1_q;
          j_d = bj_q;
          al_d = '0;
          id_d = '0;
          state_d = S_TCHK;
        end
      end
      S_TCHK: begin
        if (!(((i_x + mo_x) > n1_x || j_q != '0) && (i_q != '0 || j_q != '0))) begin
          rv_d = 1'b1;
          res_d.no_match        = 1'b0;
          res_d.score           = 16'(CW'(best_q));
          res_d.start_first     = 8'(i_q);
          res_d.end_second      = 8'(bj_q);
          res_d.aligned_pairs   = al_q;
          res_d.identical_pairs = id_q;
          state_d = S_IDLE;
        end else if (i_q == '0) begin
          j_d = j_q - LW'(1);
        end else if (j_q == '0) begin
          i_d = i_q - LW'(1);
        end else begin
          tbl_re_o = 1'b1;
          fst_re_o = 1'b1;
          snd_re_o = 1'b1;
          state_d  = S_TR1;
        end
      end
      S_TR1: begin
        cur_d = tbl_rdata_i;
        tbl_re_o    = 1'b1;
        tbl_raddr_o = tix(i_q - LW'(1), j_q - LW'(1));
        state_d = S_TR2;
      end
      S_TR2: begin
        dg_d = tbl_rdata_i;
        tbl_re_o    = 1'b1;
        tbl_raddr_o = tix(i_q - LW'(1), j_q);
        state_d = S_TD;
      end
      S_TD: begin
        if (cur_q == sadd(dg_q, eq ? '0 : mis)) begin
          al_d = al_q + 8'd1;
          if (eq) id_d = id_q + 8'd1;
          i_d = i_q - LW'(1);
          j_d = j_q - LW'(1);
        end else if (cur_q == cc) begin
          i_d = i_q - LW'(1);
        end else begin
          j_d = j_q - LW'(1);
        end
        state_d = S_TCHK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; n1_q <= n1_d; n2_q <= n2_d; bj_q <= bj_d;
    left_q <= left_d; diag_q <= diag_d; col0_q <= col0_d; ua_q <= ua_d;
    rmin_q <= rmin_d; tr_q <= tr_d; best_q <= best_d; cur_q <= cur_d; dg_q <= dg_d;
    found_q <= found_d; al_q <= al_d; id_q <= id_d; res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
    end
  end
endmodule

[rtl/core/overlap_alignment_scorer_unit.sv]
`timescale 1ns / 1ps
// Top level of the overlap alignment scorer: config registers, stores, front/back.
// Depends on oas_pkg, oas_ram, oas_front, oas_jobq, oas_back.
//
//   port group     direction  handshake           payload
//   symbol in      in         start && !busy      item_i (oas_pkg::item_t)
//   result out     out        res_valid_o strobe  res_o  (oas_pkg::result_t)
//   config write   in         cfg_we_i            cfg_idx_i, cfg_data_i
//
// An accepted symbol is written straight into its store if that store has room.
// The transaction marked last of the second sequence queues a job; busy stays high
// until its result strobes. The job fills the table cell by cell through the
// single table read port, reads and compares each candidate end column, and
// then traces back from the chosen end column.
// Reset clears lengths, queue and sequencer; the stores need no clearing.
// The result strobe lasts one cycle and cannot be held off.
module overlap_alignment_scorer_unit #(
  parameter int MAX_LEN     = 128,
  parameter int SCORE_BITS  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  oas_pkg::item_t                        item_i,
  output logic                                  res_valid_o,
  output oas_pkg::result_t                      res_o,
  input  logic                                  cfg_we_i,
  input  logic [oas_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [oas_pkg::CfgDataBits-1:0]       cfg_data_i
);
  import oas_pkg::*;
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int SAW = $clog2(MAX_LEN);
  localparam int TAW = $clog2((MAX_LEN + 1) ** 2);

  cfg_t cfg_q;

  // hold register values; reset to the documented defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mismatch_cost  <= 8'd1;
      cfg_q.indel_cost     <= 8'd1;
      cfg_q.unaligned_cost <= 8'd1;
      cfg_q.penalty_limit  <= 16'hFFFF;
      cfg_q.min_overlap    <= 8'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMismatch:  cfg_q.mismatch_cost  <= cfg_data_i[7:0];
        CfgIndel:     cfg_q.indel_cost     <= cfg_data_i[7:0];
        CfgUnaligned: cfg_q.unaligned_cost <= cfg_data_i[7:0];
        CfgLimit:     cfg_q.penalty_limit  <= cfg_data_i;
        CfgMinOvl:    cfg_q.min_overlap    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic                   accept, fst_we, snd_we, push, pop, q_empty, back_busy;
  logic [SAW-1:0]         waddr, fst_raddr, snd_raddr;
  logic [SYMBOL_BITS-1:0] wdata, fst_rdata, snd_rdata;
  logic [LW-1:0]          f_n1, f_n2, q_n1, q_n2;
  logic                   fst_re, snd_re, tbl_we, tbl_re;
  logic [TAW-1:0]         tbl_waddr, tbl_raddr;
  logic [SCORE_BITS-1:0]  tbl_wdata, tbl_rdata;

  // stall the front while a job waits or runs: the stores are shared
  assign busy   = !q_empty || back_busy;
  assign accept = start && !busy;

  oas_front #(.MaxLen(MAX_LEN), .SymbolBits(SYMBOL_BITS)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .item_i,
    .fst_we_o(fst_we), .snd_we_o(snd_we), .waddr_o(waddr), .wdata_o(wdata),
    .push_o(push), .n1_o(f_n1), .n2_o(f_n2)
  );

  oas_jobq #(.LW(LW)) u_jobq (
    .clk_i, .rst_ni, .push_i(push), .n1_i(f_n1), .n2_i(f_n2),
    .pop_i(pop), .empty_o(q_empty), .n1_o(q_n1), .n2_o(q_n2)
  );

  oas_ram #(.Width(SYMBOL_BITS), .Depth(MAX_LEN)) u_fst_ram (
    .clk_i, .we_i(fst_we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(fst_re), .raddr_i(fst_raddr), .rdata_o(fst_rdata)
  );

  oas_ram #(.Width(SYMBOL_BITS), .Depth(MAX_LEN)) u_snd_ram (
    .clk_i, .we_i(snd_we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(snd_re), .raddr_i(snd_raddr), .rdata_o(snd_rdata)
  );

  oas_ram #(.Width(SCORE_BITS), .Depth((MAX_LEN + 1) ** 2)) u_tbl_ram (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_waddr), .wdata_i(tbl_wdata),
    .re_i(tbl_re), .raddr_i(tbl_raddr), .rdata_o(tbl_rdata)
  );

  oas_back #(.MaxLen(MAX_LEN), .ScoreBits(SCORE_BITS), .SymbolBits(SYMBOL_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .job_empty_i(q_empty), .job_n1_i(q_n1), .job_n2_i(q_n2), .job_pop_o(pop),
    .busy_o(back_busy),
    .fst_re_o(fst_re), .fst_raddr_o(fst_raddr), .fst_rdata_i(fst_rdata),
    .snd_re_o(snd_re), .snd_raddr_o(snd_raddr), .snd_rdata_i(snd_rdata),
    .tbl_we_o(tbl_we), .tbl_waddr_o(tbl_waddr), .tbl_wdata_o(tbl_wdata),
    .tbl_re_o(tbl_re), .tbl_raddr_o(tbl_raddr), .tbl_rdata_i(tbl_rdata),
    .res_valid_o, .res_o
  );
endmodule
